@@ src/nonpreemptive_sjf_scheduler_macros.svh @@
// ----------------------------------------------------------------------------
// nonpreemptive_sjf_scheduler_macros
// assertion helpers shared by the scheduler checker
// ----------------------------------------------------------------------------
`ifndef NONPREEMPTIVE_SJF_SCHEDULER_MACROS_SVH
`define NONPREEMPTIVE_SJF_SCHEDULER_MACROS_SVH

// same-cycle implication
`define NSJF_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NSJF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/nsjf_pkg.sv @@
// ----------------------------------------------------------------------------
// nsjf_pkg
// shared constants and event codes of the shortest-job-first scheduler
// ----------------------------------------------------------------------------
package nsjf_pkg;

  localparam int TABLE_SIZE_DEF = 16;
  localparam int TIME_BITS_DEF  = 16;

  localparam int TIME_W  = 16;
  localparam int BURST_W = 16;
  localparam int KIND_W  = 3;
  localparam int INDEX_W = 4;

  typedef enum logic [KIND_W-1:0] {
    EV_NEW    = 3'd0,
    EV_WAIT   = 3'd1,
    EV_RUN    = 3'd2,
    EV_TERM   = 3'd3,
    EV_IDLE   = 3'd4,
    EV_LOADED = 3'd5,
    EV_FULL   = 3'd6
  } event_kind_e;

endpackage

@@ src/nsjf_if.sv @@
// ----------------------------------------------------------------------------
// nsjf_if
// request and event channels of the scheduler
// ----------------------------------------------------------------------------
interface nsjf_in_if import nsjf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               operation;
  logic [TIME_W-1:0]  arrival_time;
  logic [BURST_W-1:0] burst_time;

  modport source (output valid, operation, arrival_time, burst_time, input ready);
  modport sink   (input valid, operation, arrival_time, burst_time, output ready);
endinterface

interface nsjf_out_if import nsjf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  event_kind;
  logic [INDEX_W-1:0] job_index;
  logic [TIME_W-1:0]  event_time;
  logic [TIME_W-1:0]  start_tick;
  logic [TIME_W-1:0]  finish_tick;
  logic [TIME_W-1:0]  wait_ticks;
  logic               all_done;
  logic               last;

  modport source (output valid, event_kind, job_index, event_time, start_tick,
                  finish_tick, wait_ticks, all_done, last, input ready);
  modport sink   (input valid, event_kind, job_index, event_time, start_tick,
                  finish_tick, wait_ticks, all_done, last, output ready);
endinterface

@@ src/nsjf_table.sv @@
// ----------------------------------------------------------------------------
// nsjf_table
// job table memory: arrival and burst per slot, one write and one
// registered read port
// ----------------------------------------------------------------------------
module nsjf_table import nsjf_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF,
  localparam int AW        = $clog2(TABLE_SIZE)
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  logic [TIME_BITS-1:0] wr_arrival_i,
  input  logic [BURST_W-1:0]   wr_burst_i,
  input  logic                 rd_en_i,
  input  logic [AW-1:0]        rd_addr_i,
  output logic [TIME_BITS-1:0] rd_arrival_o,
  output logic [BURST_W-1:0]   rd_burst_o
);

  logic [TIME_BITS-1:0] arr_mem   [TABLE_SIZE];
  logic [BURST_W-1:0]   burst_mem [TABLE_SIZE];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      arr_mem[wr_addr_i]   <= wr_arrival_i;
      burst_mem[wr_addr_i] <= wr_burst_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_arrival_o <= arr_mem[rd_addr_i];
      rd_burst_o   <= burst_mem[rd_addr_i];
    end
  end

endmodule

@@ src/nonpreemptive_sjf_scheduler.sv @@
// ----------------------------------------------------------------------------
// nonpreemptive_sjf_scheduler
// non-preemptive shortest-job-first scheduler over a job table, one
// sequencer scanning the table through a single read port
//
//   channel | dir | handshake       | word
//   req_i   | in  | valid / ready   | operation, arrival_time, burst_time
//   evt_o   | out | valid / ready   | event_kind .. last, one event per word
//
// load: S_LOAD emits EV_LOADED and writes the slot, or EV_FULL when full
// tick: arrival and waiting passes while a job runs, arrival and selection
//   passes when nothing is ready, all three when a job starts; each pass
//   reads every loaded slot through the table read port
// output stalls hold the sequencer; req_i.ready only in idle
// reset clears control state; table contents undefined until loaded
// ----------------------------------------------------------------------------
module nonpreemptive_sjf_scheduler import nsjf_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  nsjf_in_if.sink    req_i,
  nsjf_out_if.source evt_o
);

  localparam int AW = $clog2(TABLE_SIZE);
  localparam int CW = $clog2(TABLE_SIZE + 1);
  localparam int WW = (TIME_BITS > TIME_W) ? TIME_BITS : TIME_W;
  localparam int SW = (AW > INDEX_W) ? AW : INDEX_W;
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_LOAD    = 4'd1;
  localparam logic [3:0] S_SEL_RD  = 4'd2;
  localparam logic [3:0] S_SEL_EV  = 4'd3;
  localparam logic [3:0] S_SEL_END = 4'd4;
  localparam logic [3:0] S_PLAN    = 4'd5;
  localparam logic [3:0] S_NEW_RD  = 4'd6;
  localparam logic [3:0] S_NEW_EV  = 4'd7;
  localparam logic [3:0] S_WT_RD   = 4'd8;
  localparam logic [3:0] S_WT_EV   = 4'd9;
  localparam logic [3:0] S_RUN     = 4'd10;
  localparam logic [3:0] S_TERM    = 4'd11;
  localparam logic [3:0] S_IDLE_EV = 4'd12;
  localparam logic [3:0] S_ADV     = 4'd13;

  logic [3:0]            state_q, state_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         fin_cnt_q, fin_cnt_d;
  logic [TABLE_SIZE-1:0] fin_q, fin_d;
  logic [TABLE_SIZE-1:0] ann_q, ann_d;
  logic [TIME_BITS-1:0]  now_q, now_d;
  logic                  run_valid_q, run_valid_d;
  logic [AW-1:0]         run_slot_q, run_slot_d;
  logic [BURST_W-1:0]    ticks_q, ticks_d;
  logic [TIME_BITS-1:0]  run_start_q, run_start_d;
  logic [TIME_BITS-1:0]  run_arr_q, run_arr_d;
  logic [BURST_W-1:0]    run_burst_q, run_burst_d;
  logic                  found_q, found_d;
  logic [AW-1:0]         best_slot_q, best_slot_d;
  logic [BURST_W-1:0]    best_burst_q, best_burst_d;
  logic [TIME_BITS-1:0]  best_arr_q, best_arr_d;
  logic                  term_q, term_d;
  logic                  done_q, done_d;
  logic [TIME_BITS-1:0]  in_arr_q, in_arr_d;
  logic [BURST_W-1:0]    in_burst_q, in_burst_d;

  logic                  ov_q, ov_d;
  event_kind_e           okind_q, okind_d;
  logic [INDEX_W-1:0]    oidx_q, oidx_d;
  logic [TIME_W-1:0]     otime_q, otime_d;
  logic [TIME_W-1:0]     ostart_q, ostart_d;
  logic [TIME_W-1:0]     ofin_q, ofin_d;
  logic [TIME_W-1:0]     owait_q, owait_d;
  logic                  odone_q, odone_d;
  logic                  olast_q, olast_d;

  logic                  tbl_we, tbl_re;
  logic [AW-1:0]         tbl_waddr;
  logic [TIME_BITS-1:0]  rd_arr;
  logic [BURST_W-1:0]    rd_burst;

  logic                  emit;
  event_kind_e           e_kind;
  logic [AW-1:0]         e_slot;
  logic [TIME_BITS-1:0]  e_start, e_fin, e_wait;
  logic                  e_done, e_last;

  logic [AW-1:0]         ix;
  logic                  rd_ready;
  logic                  out_free;
  logic [WW-1:0]         arr_x, now_x, start_x, fin_x, wait_x;
  logic [SW-1:0]         slot_x;
  logic [WW:0]           fin_sum;
  logic [TIME_BITS-1:0]  fin_sat;

  nsjf_table #(
    .TABLE_SIZE (TABLE_SIZE),
    .TIME_BITS  (TIME_BITS)
  ) u_table (
    .clk_i        (clk_i),
    .wr_en_i      (tbl_we),
    .wr_addr_i    (tbl_waddr),
    .wr_arrival_i (in_arr_q),
    .wr_burst_i   (in_burst_q),
    .rd_en_i      (tbl_re),
    .rd_addr_i    (ix),
    .rd_arrival_o (rd_arr),
    .rd_burst_o   (rd_burst)
  );

  assign ix        = idx_q[AW-1:0];
  assign tbl_waddr = count_q[AW-1:0];
  assign rd_ready  = (rd_arr <= now_q) && !fin_q[ix];
  assign out_free  = !ov_q || evt_o.ready;
  assign arr_x     = WW'(req_i.arrival_time);

  // saturating finish tick
  assign fin_sum = (WW + 1)'(run_start_q) + (WW + 1)'(run_burst_q);
  assign fin_sat = (fin_sum > (WW + 1)'(TIME_MAX)) ? TIME_MAX : fin_sum[TIME_BITS-1:0];

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    count_d      = count_q;
    fin_cnt_d    = fin_cnt_q;
    fin_d        = fin_q;
    ann_d        = ann_q;
    now_d        = now_q;
    run_valid_d  = run_valid_q;
    run_slot_d   = run_slot_q;
    ticks_d      = ticks_q;
    run_start_d  = run_start_q;
    run_arr_d    = run_arr_q;
    run_burst_d  = run_burst_q;
    found_d      = found_q;
    best_slot_d  = best_slot_q;
    best_burst_d = best_burst_q;
    best_arr_d   = best_arr_q;
    term_d       = term_q;
    done_d       = done_q;
    in_arr_d     = in_arr_q;
    in_burst_d   = in_burst_q;
    tbl_we       = 1'b0;
    tbl_re       = 1'b0;
    emit         = 1'b0;
    e_kind       = EV_IDLE;
    e_slot       = '0;
    e_start      = '0;
    e_fin        = '0;
    e_wait       = '0;
    e_done       = done_q;
    e_last       = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          in_arr_d   = arr_x[TIME_BITS-1:0];
          in_burst_d = req_i.burst_time;
          idx_d      = '0;
          found_d    = 1'b0;
          if (!req_i.operation) begin
            state_d = S_LOAD;
          end else if (run_valid_q) begin
            state_d = S_SEL_END;
          end else begin
            state_d = S_SEL_RD;
          end
        end
      end
      S_LOAD: begin
        if (out_free) begin
          emit    = 1'b1;
          e_last  = 1'b1;
          state_d = S_IDLE;
          if (count_q == CW'(TABLE_SIZE)) begin
            e_kind = EV_FULL;
            e_done = (fin_cnt_q == count_q);
          end else begin
            e_kind           = EV_LOADED;
            e_slot           = count_q[AW-1:0];
            e_done           = ((CW + 1)'(fin_cnt_q) == (CW + 1)'(count_q) + (CW + 1)'(1));
            tbl_we           = 1'b1;
            fin_d[tbl_waddr] = 1'b0;
            ann_d[tbl_waddr] = 1'b0;
            count_d          = count_q + CW'(1);
          end
        end
      end
      // selection pass: smallest burst, then earlier arrival, then lower slot
      S_SEL_RD: begin
        if (idx_q == count_q) begin
          state_d = S_SEL_END;
        end else begin
          tbl_re  = 1'b1;
          state_d = S_SEL_EV;
        end
      end
      S_SEL_EV: begin
        if (rd_ready && (!found_q || (rd_burst < best_burst_q) ||
            ((rd_burst == best_burst_q) && (rd_arr < best_arr_q)))) begin
          found_d      = 1'b1;
          best_slot_d  = ix;
          best_burst_d = rd_burst;
          best_arr_d   = rd_arr;
        end
        idx_d   = idx_q + CW'(1);
        state_d = S_SEL_RD;
      end
      S_SEL_END: begin
        if (!run_valid_q && found_q) begin
          run_valid_d = 1'b1;
          run_slot_d  = best_slot_q;
          ticks_d     = best_burst_q;
          run_start_d = now_q;
          run_arr_d   = best_arr_q;
          run_burst_d = best_burst_q;
        end
        state_d = S_PLAN;
      end
      // settle termination up front so every event carries the final all_done
      S_PLAN: begin
        term_d  = run_valid_q && (ticks_q <= BURST_W'(1));
        done_d  = ((CW + 1)'(fin_cnt_q) + (CW + 1)'(term_d) == (CW + 1)'(count_q));
        idx_d   = '0;
        state_d = S_NEW_RD;
      end
      S_NEW_RD: begin
        if (idx_q == count_q) begin
          idx_d   = '0;
          state_d = run_valid_q ? S_WT_RD : S_IDLE_EV;
        end else begin
          tbl_re  = 1'b1;
          state_d = S_NEW_EV;
        end
      end
      S_NEW_EV: begin
        if ((rd_arr <= now_q) && !ann_q[ix]) begin
          if (out_free) begin
            emit      = 1'b1;
            e_kind    = EV_NEW;
            e_slot    = ix;
            ann_d[ix] = 1'b1;
            idx_d     = idx_q + CW'(1);
            state_d   = S_NEW_RD;
          end
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = S_NEW_RD;
        end
      end
      S_WT_RD: begin
        if (idx_q == count_q) begin
          state_d = S_RUN;
        end else begin
          tbl_re  = 1'b1;
          state_d = S_WT_EV;
        end
      end
      S_WT_EV: begin
        if ((ix != run_slot_q) && rd_ready) begin
          if (out_free) begin
            emit    = 1'b1;
            e_kind  = EV_WAIT;
            e_slot  = ix;
            idx_d   = idx_q + CW'(1);
            state_d = S_WT_RD;
          end
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = S_WT_RD;
        end
      end
      S_RUN: begin
        if (out_free) begin
          emit    = 1'b1;
          e_kind  = EV_RUN;
          e_slot  = run_slot_q;
          e_last  = !term_q;
          if (ticks_q != '0) begin
            ticks_d = ticks_q - BURST_W'(1);
          end
          state_d = term_q ? S_TERM : S_ADV;
        end
      end
      S_TERM: begin
        if (out_free) begin
          emit              = 1'b1;
          e_kind            = EV_TERM;
          e_slot            = run_slot_q;
          e_start           = run_start_q;
          e_fin             = fin_sat;
          e_wait            = run_start_q - run_arr_q;
          e_last            = 1'b1;
          fin_d[run_slot_q] = 1'b1;
          fin_cnt_d         = fin_cnt_q + CW'(1);
          run_valid_d       = 1'b0;
          state_d           = S_ADV;
        end
      end
      S_IDLE_EV: begin
        if (out_free) begin
          emit    = 1'b1;
          e_kind  = EV_IDLE;
          e_last  = 1'b1;
          state_d = S_ADV;
        end
      end
      S_ADV: begin
        if (now_q != TIME_MAX) begin
          now_d = now_q + TIME_BITS'(1);
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output word register
  assign now_x   = WW'(now_q);
  assign start_x = WW'(e_start);
  assign fin_x   = WW'(e_fin);
  assign wait_x  = WW'(e_wait);
  assign slot_x  = SW'(e_slot);

  always_comb begin
    ov_d     = ov_q;
    okind_d  = okind_q;
    oidx_d   = oidx_q;
    otime_d  = otime_q;
    ostart_d = ostart_q;
    ofin_d   = ofin_q;
    owait_d  = owait_q;
    odone_d  = odone_q;
    olast_d  = olast_q;
    if (emit) begin
      ov_d     = 1'b1;
      okind_d  = e_kind;
      oidx_d   = slot_x[INDEX_W-1:0];
      otime_d  = now_x[TIME_W-1:0];
      ostart_d = start_x[TIME_W-1:0];
      ofin_d   = fin_x[TIME_W-1:0];
      owait_d  = wait_x[TIME_W-1:0];
      odone_d  = e_done;
      olast_d  = e_last;
    end else if (evt_o.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      count_q     <= '0;
      fin_cnt_q   <= '0;
      fin_q       <= '0;
      ann_q       <= '0;
      now_q       <= '0;
      run_valid_q <= 1'b0;
      run_slot_q  <= '0;
      ticks_q     <= '0;
      run_start_q <= '0;
      found_q     <= 1'b0;
      term_q      <= 1'b0;
      done_q      <= 1'b0;
      ov_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      fin_cnt_q   <= fin_cnt_d;
      fin_q       <= fin_d;
      ann_q       <= ann_d;
      now_q       <= now_d;
      run_valid_q <= run_valid_d;
      run_slot_q  <= run_slot_d;
      ticks_q     <= ticks_d;
      run_start_q <= run_start_d;
      found_q     <= found_d;
      term_q      <= term_d;
      done_q      <= done_d;
      ov_q        <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_arr_q    <= run_arr_d;
    run_burst_q  <= run_burst_d;
    best_slot_q  <= best_slot_d;
    best_burst_q <= best_burst_d;
    best_arr_q   <= best_arr_d;
    in_arr_q     <= in_arr_d;
    in_burst_q   <= in_burst_d;
    okind_q      <= okind_d;
    oidx_q       <= oidx_d;
    otime_q      <= otime_d;
    ostart_q     <= ostart_d;
    ofin_q       <= ofin_d;
    owait_q      <= owait_d;
    odone_q      <= odone_d;
    olast_q      <= olast_d;
  end

  assign req_i.ready       = (state_q == S_IDLE);
  assign evt_o.valid       = ov_q;
  assign evt_o.event_kind  = okind_q;
  assign evt_o.job_index   = oidx_q;
  assign evt_o.event_time  = otime_q;
  assign evt_o.start_tick  = ostart_q;
  assign evt_o.finish_tick = ofin_q;
  assign evt_o.wait_ticks  = owait_q;
  assign evt_o.all_done    = odone_q;
  assign evt_o.last        = olast_q;

endmodule

@@ src/nsjf_checker.sv @@
// ----------------------------------------------------------------------------
// nsjf_checker
// port-level checks of the scheduler, bound to the top level
// ----------------------------------------------------------------------------
`include "nonpreemptive_sjf_scheduler_macros.svh"

module nsjf_checker import nsjf_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [KIND_W-1:0] out_kind_i,
  input logic              out_last_i
);

  `NSJF_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "input accepted while busy")
  `NSJF_ASSERT_SAME(a_no_accept_mid_item, clk_i, rst_ni, out_valid_i && !out_last_i, !in_ready_i, "ready before the final word of an item")
  `NSJF_ASSERT_SAME(a_closing_kinds_last, clk_i, rst_ni, out_valid_i && (out_kind_i == EV_TERM || out_kind_i == EV_IDLE || out_kind_i == EV_LOADED || out_kind_i == EV_FULL), out_last_i, "closing event not flagged last")
  `NSJF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_kind_i) && $stable(out_last_i), "stalled output word changed")

endmodule

bind nonpreemptive_sjf_scheduler nsjf_checker u_nsjf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (evt_o.valid),
  .out_ready_i (evt_o.ready),
  .out_kind_i  (evt_o.event_kind),
  .out_last_i  (evt_o.last)
);
